// ===== hdl/pso_pkg.sv =====
// Shared types, constants and helpers for the particle swarm update unit.
// Depends on nothing; used by the controller, the datapath and the top-level unit.
`default_nettype none

package pso_pkg;

  localparam int unsigned MaxDimsDefault = 16;

  // Configuration register indexes.
  localparam logic [1:0] RegConstriction = 2'd0;
  localparam logic [1:0] RegInertia      = 2'd1;
  localparam logic [1:0] RegCognitive    = 2'd2;
  localparam logic [1:0] RegSocial       = 2'd3;

  localparam logic [16:0] OneQ16  = 17'd65536;
  localparam logic [31:0] HalfQ16 = 32'd32768;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] personal_best;
    logic signed [31:0] global_best;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic [16:0]        rand_cognitive;
    logic [16:0]        rand_social;
    logic [16:0]        rand_direction;
    logic               is_real;
    logic [15:0]        generation;
    logic               last_dimension;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_velocity;
    logic signed [31:0] new_position;
    logic               above_upper;
    logic               below_lower;
    logic               final_result;
  } out_item_t;

  // Controller steps.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_CONSTR,
    ST_VDIV,
    ST_VMIN,
    ST_BOUND,
    ST_FDIV_UP,
    ST_FDIV_LO,
    ST_STORE,
    ST_FLUSH_RD,
    ST_FLUSH_MUL,
    ST_FLUSH_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic sum;
    logic constr;
    logic vdiv_start;
    logic vmin;
    logic bound;
    logic fdiv_start;
    logic fdiv_sel_lo;
    logic fdiv_done_take;
    logic store;
    logic flush_rd;
    logic flush_mul;
    logic flush_out;
    logic flush_end;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
    logic up;
    logic lo;
    logic last;
    logic full;
    logic empty;
    logic at_end;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
    if (a > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (a < -64'sd2147483648) return 32'sh80000000;
    return a[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pso_divider.sv =====
// Radix-2 restoring divider for unsigned 48-bit by 40-bit quotients.
// Uses no package items; instantiated by the datapath.
`default_nettype none

module pso_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] dividend,
  input  wire logic [39:0] divisor,
  output logic             busy,
  output logic [47:0]      quotient
);

  logic [5:0]  count;
  logic [47:0] quo;
  logic [40:0] rem;
  logic [39:0] dsr;
  logic [40:0] trial;

  assign trial = {rem[39:0], quo[47]} - {1'b0, dsr};

  // One quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= 6'd48;
      quo   <= dividend;
      rem   <= '0;
      dsr   <= divisor;
    end else if (count != 6'd0) begin
      count <= count - 6'd1;
      if (!trial[40]) begin
        rem <= trial;
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= {rem[39:0], quo[47]};
        quo <= {quo[46:0], 1'b0};
      end
    end
  end

  assign busy     = (count != 6'd0);
  assign quotient = quo;

endmodule

`default_nettype wire

// ===== hdl/pso_datapath.sv =====
// Datapath: arithmetic registers, the dimension store and the shared divider.
// Depends on pso_pkg and pso_divider.
`default_nettype none

module pso_datapath #(
  parameter int unsigned MAX_DIMS = pso_pkg::MaxDimsDefault
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pso_pkg::cmd_t    cmd,
  input  wire pso_pkg::in_item_t in_item,
  input  wire logic [15:0]      constriction,
  input  wire logic [15:0]      inertia_weight,
  input  wire logic [15:0]      cognitive_weight,
  input  wire logic [15:0]      social_weight,
  output pso_pkg::status_t      status,
  output pso_pkg::out_item_t    out_item
);

  localparam int unsigned AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned CW = $clog2(MAX_DIMS + 1);

  pso_pkg::in_item_t item;
  logic signed [63:0] acc;
  logic signed [63:0] term;
  logic [16:0]        cr1;
  logic [16:0]        cr2;
  logic signed [31:0] vel;
  logic [31:0]        vmin;
  logic               up;
  logic               lo;
  logic [16:0]        fraction;
  logic [CW-1:0]      count;
  logic [CW-1:0]      rd_idx;

  logic signed [31:0] pos_mem [MAX_DIMS];
  logic signed [31:0] vel_mem [MAX_DIMS];
  logic               up_mem  [MAX_DIMS];
  logic               lo_mem  [MAX_DIMS];
  logic signed [31:0] rd_pos;
  logic signed [31:0] rd_vel;
  logic               rd_up;
  logic               rd_lo;
  logic signed [63:0] scaled;

  logic        div_start;
  logic [47:0] div_dividend;
  logic [39:0] div_divisor;
  logic        div_busy;
  logic [47:0] div_quotient;

  logic signed [32:0] diff_p;
  logic signed [32:0] diff_g;
  logic signed [32:0] moved;
  logic [31:0]        abs_x;
  logic [31:0]        abs_v;
  logic signed [32:0] gap;
  logic [32:0]        abs_gap;
  logic [16:0]        frac_val;
  logic [17:0]        r_sel;
  logic [49:0]        repl;
  logic signed [63:0] constr_prod;

  assign diff_p = 33'(item.personal_best) - 33'(item.position);
  assign diff_g = 33'(item.global_best) - 33'(item.position);
  assign moved  = 33'(item.position) + 33'(vel);
  assign abs_x  = item.position[31] ? 32'(-33'(item.position)) : item.position;
  assign abs_v  = vel[31] ? 32'(-33'(vel)) : vel;
  assign gap    = cmd.fdiv_sel_lo ? (33'(item.lower_bound) - 33'(item.position))
                                  : (33'(item.upper_bound) - 33'(item.position));
  assign abs_gap = gap[32] ? 33'(-gap) : gap;
  assign r_sel  = (item.rand_direction >= 17'd32768) ? 18'(item.rand_cognitive)
                                                     : 18'(item.rand_social);
  assign repl   = (50'(r_sel) + 50'(pso_pkg::OneQ16)) * 50'(vmin);
  assign constr_prod = (acc >>> 12) * $signed({48'd0, constriction});

  // Divider operands: vmin is |x| / (100*(g+1)); the fraction is |gap|*2^15 / |v|.
  always_comb begin
    div_start = 1'b0;
    div_dividend = '0;
    div_divisor = '0;
    if (cmd.vdiv_start) begin
      div_start    = 1'b1;
      div_dividend = 48'(abs_x);
      div_divisor  = 40'((17'(item.generation) + 17'd1) * 24'd100);
    end else if (cmd.fdiv_start) begin
      div_start    = 1'b1;
      div_dividend = {abs_gap[32:0], 15'd0};
      div_divisor  = 40'(abs_v);
    end
  end

  pso_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // Minimum speed: the divider quotient for real parameters, else one half.
  // The quotient is complete and held when the vmin step reads it.
  assign vmin = item.is_real ? div_quotient[31:0] : pso_pkg::HalfQ16;

  // Fraction from the divider, capped at one; zero for a zero velocity.
  assign frac_val = (vel == 32'sd0) ? 17'd0 :
                    (div_quotient > 48'(pso_pkg::OneQ16)) ? pso_pkg::OneQ16 :
                    div_quotient[16:0];

  // Per-dimension arithmetic sequence.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
      cr1  <= 17'((33'(cognitive_weight) * 33'(in_item.rand_cognitive)) >> 16);
      cr2  <= 17'((33'(social_weight) * 33'(in_item.rand_social)) >> 16);
      acc  <= 64'(in_item.velocity) * $signed({48'd0, inertia_weight});
    end
    if (cmd.mul1) term <= $signed({47'd0, cr1}) * 64'(diff_p);
    if (cmd.mul2) begin
      acc  <= acc + term;
      term <= $signed({47'd0, cr2}) * 64'(diff_g);
    end
    if (cmd.sum)    acc <= acc + term;
    if (cmd.constr) vel <= pso_pkg::sat32(constr_prod >>> 12);
    if (cmd.vmin) begin
      if ({1'b0, abs_v} < {1'b0, vmin}) begin
        if (item.rand_direction >= 17'd32768) vel <= pso_pkg::sat32(64'(repl >> 16));
        else vel <= pso_pkg::sat32(-64'(repl >> 16));
      end
    end
    if (cmd.bound) begin
      up <= moved > 33'(item.upper_bound);
      lo <= moved < 33'(item.lower_bound);
    end
  end

  // Running minimum fraction and count of stored dimensions.
  always_ff @(posedge clk) begin
    if (rst) begin
      fraction <= pso_pkg::OneQ16;
      count    <= '0;
    end else begin
      if (cmd.fdiv_done_take && frac_val < fraction) fraction <= frac_val;
      if (cmd.store) count <= count + CW'(1);
      if (cmd.flush_end) begin
        fraction <= pso_pkg::OneQ16;
        count    <= '0;
      end
    end
  end

  // Dimension store.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      pos_mem[count[AW-1:0]] <= item.position;
      vel_mem[count[AW-1:0]] <= vel;
      up_mem[count[AW-1:0]]  <= up;
      lo_mem[count[AW-1:0]]  <= lo;
    end
    if (cmd.flush_rd) begin
      rd_pos <= pos_mem[rd_idx[AW-1:0]];
      rd_vel <= vel_mem[rd_idx[AW-1:0]];
      rd_up  <= up_mem[rd_idx[AW-1:0]];
      rd_lo  <= lo_mem[rd_idx[AW-1:0]];
    end
  end

  // Flush read pointer and output formation.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.flush_end) begin
      rd_idx <= '0;
    end else if (cmd.flush_out) begin
      rd_idx <= rd_idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_mul) scaled <= (64'(rd_vel) * $signed({47'd0, fraction})) >>> 16;
    if (cmd.flush_out) begin
      out_item.new_velocity <= scaled[31:0];
      out_item.new_position <= pso_pkg::sat32(64'(rd_pos) + scaled);
      out_item.above_upper  <= rd_up;
      out_item.below_lower  <= rd_lo;
      out_item.final_result <= (rd_idx + CW'(1) == count);
    end
  end

  assign status.div_busy = div_busy;
  assign status.up       = up;
  assign status.lo       = lo;
  assign status.last     = item.last_dimension;
  assign status.full     = (count == CW'(MAX_DIMS));
  assign status.empty    = (count == '0);
  assign status.at_end   = (rd_idx + CW'(1) == count);

endmodule

`default_nettype wire

// ===== hdl/pso_controller.sv =====
// Controller state machine: sequences one dimension and the final flush.
// Depends on pso_pkg.
`default_nettype none

module pso_controller (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire pso_pkg::status_t status,
  output pso_pkg::cmd_t        cmd
);

  pso_pkg::state_t state;
  pso_pkg::state_t state_next;
  logic            out_valid_next;
  logic            out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pso_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != pso_pkg::ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      pso_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = pso_pkg::ST_MUL1;
        end
      end
      pso_pkg::ST_MUL1: begin
        if (status.full) begin
          state_next = status.last && !status.empty ? pso_pkg::ST_FLUSH_RD
                                                    : pso_pkg::ST_IDLE;
        end else begin
          cmd.mul1   = 1'b1;
          state_next = pso_pkg::ST_MUL2;
        end
      end
      pso_pkg::ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = pso_pkg::ST_SUM;
      end
      pso_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = pso_pkg::ST_CONSTR;
      end
      pso_pkg::ST_CONSTR: begin
        cmd.constr     = 1'b1;
        cmd.vdiv_start = 1'b1;
        state_next     = pso_pkg::ST_VDIV;
      end
      pso_pkg::ST_VDIV: begin
        if (!status.div_busy) state_next = pso_pkg::ST_VMIN;
      end
      pso_pkg::ST_VMIN: begin
        cmd.vmin   = 1'b1;
        state_next = pso_pkg::ST_BOUND;
      end
      pso_pkg::ST_BOUND: begin
        cmd.bound  = 1'b1;
        state_next = pso_pkg::ST_FDIV_UP;
      end
      pso_pkg::ST_FDIV_UP: begin
        if (status.up) begin
          cmd.fdiv_start = 1'b1;
          state_next     = pso_pkg::ST_FDIV_LO;
        end else begin
          state_next = pso_pkg::ST_FDIV_LO;
        end
      end
      pso_pkg::ST_FDIV_LO: begin
        // Wait for any upper-bound quotient, then start the lower one if that bound is violated.
        if (!status.div_busy) begin
          if (status.up) cmd.fdiv_done_take = 1'b1;
          if (status.lo) begin
            cmd.fdiv_sel_lo = 1'b1;
            cmd.fdiv_start  = 1'b1;
          end
          state_next = pso_pkg::ST_STORE;
        end
      end
      pso_pkg::ST_STORE: begin
        if (!status.div_busy) begin
          if (status.lo) cmd.fdiv_done_take = 1'b1;
          cmd.store  = 1'b1;
          state_next = status.last ? pso_pkg::ST_FLUSH_RD : pso_pkg::ST_IDLE;
        end
      end
      pso_pkg::ST_FLUSH_RD: begin
        cmd.flush_rd = 1'b1;
        state_next   = pso_pkg::ST_FLUSH_MUL;
      end
      pso_pkg::ST_FLUSH_MUL: begin
        cmd.flush_mul = 1'b1;
        state_next    = pso_pkg::ST_FLUSH_OUT;
      end
      pso_pkg::ST_FLUSH_OUT: begin
        if (out_free) begin
          cmd.flush_out  = 1'b1;
          out_valid_next = 1'b1;
          if (status.at_end) begin
            cmd.flush_end = 1'b1;
            state_next    = pso_pkg::ST_IDLE;
          end else begin
            state_next = pso_pkg::ST_FLUSH_RD;
          end
        end
      end
      default: state_next = pso_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/pso_particle_update_unit.sv =====
// Particle swarm velocity/position update unit, one dimension per transaction.
// A dimension that violates no bound occupies the unit, from its acceptance to the
// next possible one, for the multiply chain, the minimum-speed quotient on the
// shared radix-2 divider, the minimum speed, the bound check and the store.
// Each violated bound adds its fraction quotient on the divider. A dimension
// that arrives on a full store is dropped. On the dimension marked last, the
// stored dimensions leave one result at a time while the output is not stalled.
// Configuration is through a 32-bit APB port.
// Depends on pso_pkg, pso_controller, pso_datapath and pso_divider.
`default_nettype none

module pso_particle_update_unit #(
  parameter int unsigned MAX_DIMS = pso_pkg::MaxDimsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pso_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pso_pkg::out_item_t      out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [15:0] constriction;
  logic [15:0] inertia_weight;
  logic [15:0] cognitive_weight;
  logic [15:0] social_weight;
  pso_pkg::cmd_t    cmd;
  pso_pkg::status_t status;

  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      constriction     <= 16'd4096;
      inertia_weight   <= 16'd4915;
      cognitive_weight <= 16'd8192;
      social_weight    <= 16'd8192;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        pso_pkg::RegConstriction: constriction     <= pwdata[15:0];
        pso_pkg::RegInertia:      inertia_weight   <= pwdata[15:0];
        pso_pkg::RegCognitive:    cognitive_weight <= pwdata[15:0];
        pso_pkg::RegSocial:       social_weight    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr[3:2])
      pso_pkg::RegConstriction: prdata = {16'd0, constriction};
      pso_pkg::RegInertia:      prdata = {16'd0, inertia_weight};
      pso_pkg::RegCognitive:    prdata = {16'd0, cognitive_weight};
      pso_pkg::RegSocial:       prdata = {16'd0, social_weight};
      default:                  prdata = '0;
    endcase
  end

  pso_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pso_datapath #(.MAX_DIMS(MAX_DIMS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .in_item          (in_data),
    .constriction     (constriction),
    .inertia_weight   (inertia_weight),
    .cognitive_weight (cognitive_weight),
    .social_weight    (social_weight),
    .status           (status),
    .out_item         (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/tb_pso_particle_update_unit.sv =====
// Testbench for pso_particle_update_unit: random and directed dimensions are sent,
// each result is compared with a built-in predictor of the swarm update arithmetic.
// Depends on pso_pkg and the RTL in hdl/.
`default_nettype none

module tb_pso_particle_update_unit;

  localparam int Dims = 16;
  localparam int StallLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  pso_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pso_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pso_particle_update_unit i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of the registers and per-particle store.
  logic [15:0] gain_c, gain_w, gain_c1, gain_c2;
  logic signed [31:0] held_pos [Dims];
  logic signed [31:0] held_vel [Dims];
  logic held_up [Dims];
  logic held_lo [Dims];
  longint frac_min;
  int held_count;
  pso_pkg::out_item_t expected_updates[$];
  int fail_count = 0;
  int idle_cycles = 0;
  int stall_mode = 0;

  function automatic longint floor_sh(longint a, int s);
    return a >>> s;
  endfunction

  function automatic longint clamp32(longint a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  function automatic longint mag(longint a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic void shrink_for(longint bnd, longint x, longint v);
    longint f;
    if (v == 0) f = 0;
    else begin
      f = (mag(bnd - x) * 32768) / mag(v);
      if (f > 65536) f = 65536;
    end
    if (f < frac_min) frac_min = f;
  endfunction

  // Work out the results that one accepted dimension causes.
  function automatic void predict_update(pso_pkg::in_item_t it);
    longint x, sum, v, vmin, moved, nv, np;
    longint cr1, cr2;
    pso_pkg::out_item_t o;
    if (held_count < Dims) begin
      x = it.position;
      cr1 = (longint'(gain_c1) * longint'(it.rand_cognitive)) >>> 16;
      cr2 = (longint'(gain_c2) * longint'(it.rand_social)) >>> 16;
      sum = longint'(gain_w) * longint'(it.velocity)
          + cr1 * (longint'(it.personal_best) - x)
          + cr2 * (longint'(it.global_best) - x);
      v = floor_sh(sum, 12) * longint'(gain_c);
      v = clamp32(floor_sh(v, 12));
      if (it.is_real) vmin = mag(x) / (100 * (longint'(it.generation) + 1));
      else vmin = 32768;
      if (mag(v) < vmin) begin
        if (it.rand_direction >= 17'd32768)
          v = ((65536 + longint'(it.rand_cognitive)) * vmin) >>> 16;
        else
          v = -(((65536 + longint'(it.rand_social)) * vmin) >>> 16);
        v = clamp32(v);
      end
      moved = x + v;
      held_up[held_count] = moved > longint'(it.upper_bound);
      held_lo[held_count] = moved < longint'(it.lower_bound);
      if (held_up[held_count]) shrink_for(it.upper_bound, x, v);
      if (held_lo[held_count]) shrink_for(it.lower_bound, x, v);
      held_pos[held_count] = x[31:0];
      held_vel[held_count] = v[31:0];
      held_count++;
    end
    if (it.last_dimension) begin
      for (int k = 0; k < held_count; k++) begin
        nv = floor_sh(longint'(held_vel[k]) * frac_min, 16);
        np = clamp32(longint'(held_pos[k]) + nv);
        o.new_velocity = nv[31:0];
        o.new_position = np[31:0];
        o.above_upper = held_up[k];
        o.below_lower = held_lo[k];
        o.final_result = (k == held_count - 1);
        expected_updates.push_back(o);
      end
      frac_min = 65536;
      held_count = 0;
    end
  endfunction

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    pso_pkg::out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_updates.size() == 0) begin
        $error("unexpected result: velocity %0d position %0d",
               out_data.new_velocity, out_data.new_position);
        fail_count++;
      end else begin
        e = expected_updates.pop_front();
        if (out_data.new_velocity !== e.new_velocity) begin
          $error("new_velocity expected %0d actual %0d", e.new_velocity, out_data.new_velocity);
          fail_count++;
        end
        if (out_data.new_position !== e.new_position) begin
          $error("new_position expected %0d actual %0d", e.new_position, out_data.new_position);
          fail_count++;
        end
        if (out_data.above_upper !== e.above_upper) begin
          $error("above_upper expected %0b actual %0b", e.above_upper, out_data.above_upper);
          fail_count++;
        end
        if (out_data.below_lower !== e.below_lower) begin
          $error("below_lower expected %0b actual %0b", e.below_lower, out_data.below_lower);
          fail_count++;
        end
        if (out_data.final_result !== e.final_result) begin
          $error("final_result expected %0b actual %0b", e.final_result, out_data.final_result);
          fail_count++;
        end
      end
    end
  end

  // Receiver stall pattern, changed at the falling edge.
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send one dimension, holding it until accepted; the sender then rests with in_valid low.
  task automatic send_dimension(pso_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_update(it);
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic burst_gap();
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 30)) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      pso_pkg::RegConstriction: gain_c = val;
      pso_pkg::RegInertia: gain_w = val;
      pso_pkg::RegCognitive: gain_c1 = val;
      default: gain_c2 = val;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    while (expected_updates.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_gains(logic [15:0] c, logic [15:0] w, logic [15:0] a, logic [15:0] b);
    drain();
    write_reg(pso_pkg::RegConstriction, c);
    write_reg(pso_pkg::RegInertia, w);
    write_reg(pso_pkg::RegCognitive, a);
    write_reg(pso_pkg::RegSocial, b);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
    endcase
  endfunction

  function automatic pso_pkg::in_item_t rand_dimension(logic last);
    pso_pkg::in_item_t it;
    logic signed [31:0] a, b;
    it.position = rand_coord();
    it.velocity = ($urandom_range(0, 3) == 0) ? rand_coord()
                                              : $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
    it.personal_best = rand_coord();
    it.global_best = rand_coord();
    a = rand_coord();
    b = rand_coord();
    if ($urandom_range(0, 7) == 0) begin
      it.lower_bound = a;
      it.upper_bound = b;
    end else begin
      it.lower_bound = (a < b) ? a : b;
      it.upper_bound = (a < b) ? b : a;
    end
    it.rand_cognitive = ($urandom_range(0, 9) == 0) ? 17'($urandom())
                                                    : 17'($urandom_range(0, 65536));
    it.rand_social = ($urandom_range(0, 9) == 0) ? 17'($urandom())
                                                 : 17'($urandom_range(0, 65536));
    it.rand_direction = 17'($urandom());
    it.is_real = 1'($urandom_range(0, 1));
    it.generation = ($urandom_range(0, 1)) ? 16'($urandom()) : 16'($urandom_range(0, 20));
    it.last_dimension = last;
    return it;
  endfunction

  function automatic pso_pkg::in_item_t base_dimension(logic last);
    pso_pkg::in_item_t it;
    it = '0;
    it.lower_bound = -32'sd655360;
    it.upper_bound = 32'sd655360;
    it.rand_cognitive = 17'd32768;
    it.rand_social = 17'd32768;
    it.last_dimension = last;
    return it;
  endfunction

  // Directed: field extremes, minimum speed both ways, zero-velocity clamp,
  // crossed bounds, oversize random weights and store overflow.
  task automatic test_directed();
    pso_pkg::in_item_t it;
    it = base_dimension(1'b0);
    it.velocity = 32'sh7FFFFFFF;
    it.position = 32'sh7FFFFFFF;
    it.personal_best = 32'sh80000000;
    it.global_best = 32'sh80000000;
    it.rand_cognitive = 17'h1FFFF;
    it.rand_social = 17'h1FFFF;
    send_dimension(it);
    it = base_dimension(1'b0);
    it.position = 32'sh80000000;
    it.velocity = 32'sh80000000;
    it.personal_best = 32'sh7FFFFFFF;
    it.global_best = 32'sh7FFFFFFF;
    it.generation = 16'hFFFF;
    it.is_real = 1'b1;
    send_dimension(it);
    it = base_dimension(1'b0);
    it.rand_direction = 17'h1FFFF;
    send_dimension(it);
    it = base_dimension(1'b1);
    it.rand_direction = 17'd0;
    send_dimension(it);
    // Zero velocity outside the bounds: the fraction goes to zero.
    set_gains(16'd0, 16'd4915, 16'd8192, 16'd8192);
    it = base_dimension(1'b0);
    it.position = 32'sd1310720;
    it.is_real = 1'b1;
    it.generation = 16'hFFFF;
    send_dimension(it);
    it = base_dimension(1'b1);
    it.lower_bound = 32'sd65536;
    it.upper_bound = -32'sd65536;
    it.rand_direction = 17'd65536;
    send_dimension(it);
    set_gains(16'd4096, 16'd4915, 16'd8192, 16'd8192);
    // Eighteen dimensions: the last two land on a full store.
    for (int k = 0; k < 18; k++) send_dimension(rand_dimension(k == 17));
  endtask

  // Random particles at the current register settings.
  task automatic test_random(int items);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
        send_dimension(rand_dimension(k == n - 1));
        burst_gap();
      end
      sent += n;
      if ($urandom_range(0, 9) == 0) drain();
    end
  endtask

  initial begin
    gain_c = 16'd4096;
    gain_w = 16'd4915;
    gain_c1 = 16'd8192;
    gain_c2 = 16'd8192;
    frac_min = 65536;
    held_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(100);
    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random(60);
    set_gains(16'd2000, 16'd0, 16'd300, 16'd12000);
    test_random(80);
    set_gains(16'd4096, 16'd4915, 16'd8192, 16'd8192);
    test_random(60);
    drain();
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

`default_nettype wire

// ===== sim.f =====
hdl/pso_pkg.sv
hdl/pso_divider.sv
hdl/pso_datapath.sv
hdl/pso_controller.sv
hdl/pso_particle_update_unit.sv
tb/tb_pso_particle_update_unit.sv
